[src/tfwm_pkg.sv]
// ----------------------------------------------------------------------------
// Topic filter wildcard match: shared package
// Command codes, wildcard characters, matcher phases and the per-beat
// step bundle that the top level hands to every slot matcher.
// ----------------------------------------------------------------------------
package tfwm_pkg;

	localparam int FILTER_SLOTS_DEF = 8;
	localparam int FILTER_LEN_DEF   = 64;

	localparam int CMD_W  = 2;
	localparam int SLOT_W = 3;
	localparam int CHAR_W = 8;

	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TOPIC  = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_HASH  = 8'h23;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

	// Matcher phase of one slot while a topic streams in.
	typedef enum logic [3:0] {
		PH_COMPARE = 4'b0001,
		PH_PLUS    = 4'b0010,
		PH_FAILED  = 4'b0100,
		PH_MATCHED = 4'b1000
	} phase_t;

	// One executed beat, broadcast to all slot matchers.
	typedef struct packed {
		logic              append;
		logic              clear;
		logic              topic;
		logic [SLOT_W-1:0] slot;
		logic [CHAR_W-1:0] char_byte;
		logic              last;
		logic              seg_start;
	} step_t;

endpackage

[src/tfwm_if.sv]
// ----------------------------------------------------------------------------
// Topic filter wildcard match: channel interfaces
// Valid/ready channels for command beats and for match results.
// ----------------------------------------------------------------------------
interface tfwm_in_if;
	logic                              valid;
	logic                              ready;
	logic [tfwm_pkg::CMD_W-1:0]        cmd;
	logic [tfwm_pkg::SLOT_W-1:0]       slot;
	logic [tfwm_pkg::CHAR_W-1:0]       char_byte;
	logic                              last;

	modport source (output valid, cmd, slot, char_byte, last, input ready);
	modport sink   (input valid, cmd, slot, char_byte, last, output ready);
endinterface

interface tfwm_out_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, matched, input ready);
	modport sink   (input valid, matched, output ready);
endinterface

[src/tfwm_slot.sv]
// ----------------------------------------------------------------------------
// Topic filter wildcard match: slot matcher
// Holds one filter in a local byte memory and follows the streamed topic
// one character per beat. The bytes at the cursor and the one after it are
// fetched into registers from the next cursor value.
// ----------------------------------------------------------------------------
module tfwm_slot #(
	parameter int SLOT_ID    = 0,
	parameter int FILTER_LEN = tfwm_pkg::FILTER_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tfwm_pkg::step_t step,
	output logic           hit
);
	import tfwm_pkg::*;

	localparam int AW    = $clog2(FILTER_LEN);
	localparam int LEN_W = $clog2(FILTER_LEN + 1);
	localparam int CUR_W = $clog2(FILTER_LEN + 3);
	localparam int DEPTH = 2 ** AW;
	localparam logic [31:0] ID = SLOT_ID;

	logic [CHAR_W-1:0] mem [DEPTH];

	logic [LEN_W-1:0]  len_q;
	logic              used_q;
	logic              ovf_q;
	logic [CUR_W-1:0]  cur_q;
	phase_t            ph_q;
	logic [CHAR_W-1:0] b0_q;
	logic [CHAR_W-1:0] b1_q;

	logic              sel;
	logic [CUR_W-1:0]  len_ext;
	logic [CUR_W-1:0]  cur_p1;
	logic              at_end0;
	logic              at_end1;
	logic              seg_end0;
	logic              seg_end1;
	logic              has_room;
	logic              we;
	logic [AW-1:0]     waddr;

	phase_t            ph;
	logic [CUR_W-1:0]  cur;
	logic [LEN_W-1:0]  len_nxt;
	logic              used_nxt;
	logic              ovf_nxt;
	logic [CUR_W-1:0]  cur_nxt;
	logic [CUR_W-1:0]  cur_nxt_p1;
	phase_t            ph_nxt;
	logic [AW-1:0]     raddr0;
	logic [AW-1:0]     raddr1;

	assign sel      = (32'(step.slot) == ID);
	assign len_ext  = CUR_W'(len_q);
	assign cur_p1   = cur_q + CUR_W'(1);
	assign at_end0  = (cur_q >= len_ext);
	assign at_end1  = (cur_p1 >= len_ext);
	assign seg_end0 = at_end0 || (b0_q == CHAR_SLASH);
	assign seg_end1 = at_end1 || (b1_q == CHAR_SLASH);
	assign has_room = (len_q < LEN_W'(FILTER_LEN));
	assign we       = step.append && sel && has_room;
	assign waddr    = len_q[AW-1:0];

	// One topic character against this filter.
	always_comb begin
		ph  = ph_q;
		cur = cur_q;
		if (step.seg_start && ph == PH_COMPARE) begin
			if (at_end0) begin
				ph = PH_FAILED;
			end else if (b0_q == CHAR_HASH) begin
				ph = PH_MATCHED;
			end else if (b0_q == CHAR_PLUS && seg_end1) begin
				ph = PH_PLUS;
			end
		end

		if (ph == PH_PLUS) begin
			if (step.char_byte == CHAR_SLASH) begin
				cur = cur_q + CUR_W'(2);
				ph  = PH_COMPARE;
			end
		end else if (ph == PH_COMPARE) begin
			if (step.char_byte == CHAR_SLASH) begin
				if (seg_end0) begin
					cur = cur_p1;
				end else begin
					ph = PH_FAILED;
				end
			end else if (!at_end0 && b0_q == step.char_byte) begin
				cur = cur_p1;
			end else begin
				ph = PH_FAILED;
			end
		end

		// The end of the topic closes its last segment. A compare phase that
		// survives a non-slash character has always moved one byte on.
		if (step.last && step.char_byte != CHAR_SLASH) begin
			if (ph == PH_PLUS) begin
				cur = cur_q + CUR_W'(2);
				ph  = PH_COMPARE;
			end else if (ph == PH_COMPARE) begin
				if (seg_end1) begin
					cur = cur_p1 + CUR_W'(1);
				end else begin
					ph = PH_FAILED;
				end
			end
		end
	end

	assign hit = step.topic && step.last && used_q && !ovf_q &&
		(ph == PH_MATCHED || (ph == PH_COMPARE && cur >= len_ext));

	always_comb begin
		len_nxt  = len_q;
		used_nxt = used_q;
		ovf_nxt  = ovf_q;
		cur_nxt  = cur_q;
		ph_nxt   = ph_q;
		if (step.clear && sel) begin
			len_nxt  = '0;
			used_nxt = 1'b0;
			ovf_nxt  = 1'b0;
			cur_nxt  = '0;
			ph_nxt   = PH_COMPARE;
		end else if (step.append && sel) begin
			used_nxt = 1'b1;
			if (has_room) begin
				len_nxt = len_q + LEN_W'(1);
			end else begin
				ovf_nxt = 1'b1;
			end
		end else if (step.topic) begin
			if (step.last) begin
				cur_nxt = '0;
				ph_nxt  = PH_COMPARE;
			end else begin
				cur_nxt = cur;
				ph_nxt  = ph;
			end
		end
	end

	assign cur_nxt_p1 = cur_nxt + CUR_W'(1);
	assign raddr0     = cur_nxt[AW-1:0];
	assign raddr1     = cur_nxt_p1[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			used_q <= 1'b0;
			ovf_q  <= 1'b0;
			cur_q  <= '0;
			ph_q   <= PH_COMPARE;
		end else begin
			len_q  <= len_nxt;
			used_q <= used_nxt;
			ovf_q  <= ovf_nxt;
			cur_q  <= cur_nxt;
			ph_q   <= ph_nxt;
		end
	end

	// Filter memory with registered reads; a byte written in the same cycle
	// is forwarded into the fetch registers.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= step.char_byte;
		end
		b0_q <= (we && waddr == raddr0) ? step.char_byte : mem[raddr0];
		b1_q <= (we && waddr == raddr1) ? step.char_byte : mem[raddr1];
	end

endmodule

[src/topic_filter_wildcard_match_unit.sv]
// ----------------------------------------------------------------------------
// Topic filter wildcard match unit
// A table of topic filters built by appending characters, matched in
// parallel against a topic that streams in one character per beat.
// ----------------------------------------------------------------------------
//  channel  dir   payload                        beats
//  item     sink  cmd, slot, char_byte, last     one per command or character
//  result   src   matched                        one per topic, on its last char
//
// Every slot matcher handles one beat per cycle, so a beat can be taken on
// every clock unless a topic's last character waits on a full result;
// each beat passes the input register, and the result register loads as
// the last character leaves it. The per-slot filter memories prefetch the
// bytes at the next cursor. Reset clears all slots and needs no fill pass.
// While a result waits to be taken, beats that cause no result still flow.
// ----------------------------------------------------------------------------
module topic_filter_wildcard_match_unit #(
	parameter int FILTER_SLOTS = tfwm_pkg::FILTER_SLOTS_DEF,
	parameter int FILTER_LEN   = tfwm_pkg::FILTER_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tfwm_in_if.sink    item,
	tfwm_out_if.source result
);
	import tfwm_pkg::*;

	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	logic              seg_start_q;
	logic              out_valid_q;
	logic              matched_q;

	logic              produces;
	logic              out_free;
	logic              fire;
	step_t             step;
	logic [FILTER_SLOTS-1:0] hits;

	assign produces = (cmd_s1 == CMD_TOPIC) && last_s1;
	assign out_free = !out_valid_q || result.ready;
	assign fire     = valid_s1 && (!produces || out_free);

	assign item.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			cmd_s1  <= item.cmd;
			slot_s1 <= item.slot;
			char_s1 <= item.char_byte;
			last_s1 <= item.last;
		end
	end

	always_comb begin
		step.append    = fire && (cmd_s1 == CMD_APPEND);
		step.clear     = fire && (cmd_s1 == CMD_CLEAR);
		step.topic     = fire && (cmd_s1 == CMD_TOPIC);
		step.slot      = slot_s1;
		step.char_byte = char_s1;
		step.last      = last_s1;
		step.seg_start = seg_start_q;
	end

	for (genvar s = 0; s < FILTER_SLOTS; s++) begin : g_slot
		tfwm_slot #(
			.SLOT_ID    (s),
			.FILTER_LEN (FILTER_LEN)
		) u_slot (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (step),
			.hit    (hits[s])
		);
	end

	// A slash opens a new segment, and the end of a topic restarts matching.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_start_q <= 1'b1;
		end else if (step.topic) begin
			seg_start_q <= (char_s1 == CHAR_SLASH) || last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && produces) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && produces) begin
			matched_q <= |hits;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.matched = matched_q;

endmodule

[bench/topic_filter_wildcard_match_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Topic filter wildcard match unit testbench
// Builds filters in the slot table and streams topics past them, with the
// sender and the receiver idling at random in several stages. A scoreboard
// predicts every match result beat from its own copy of the slot matchers
// and compares the results in order.
// ----------------------------------------------------------------------------
module topic_filter_wildcard_match_unit_tb;
	import tfwm_pkg::*;

	typedef logic [CHAR_W-1:0] chars_t[$];

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_BEATS = 1000;
	localparam int MIN_TOPICS   = 60;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;

	class match_scoreboard;
		logic [CHAR_W-1:0] fbytes [FILTER_SLOTS_DEF][FILTER_LEN_DEF];
		int unsigned flen [FILTER_SLOTS_DEF];
		bit          used [FILTER_SLOTS_DEF];
		bit          ovf  [FILTER_SLOTS_DEF];
		int unsigned cur  [FILTER_SLOTS_DEF];
		phase_t      ph   [FILTER_SLOTS_DEF];
		bit          seg_start;
		bit          expected_matched[$];
		int          mismatches;
		int          topics_done;

		function new();
			foreach (flen[s]) begin
				flen[s] = 0;
				used[s] = 1'b0;
				ovf[s] = 1'b0;
				foreach (fbytes[s][p])
					fbytes[s][p] = '0;
			end
			mismatches = 0;
			topics_done = 0;
			restart();
		endfunction

		function void restart();
			foreach (cur[s]) begin
				cur[s] = 0;
				ph[s] = PH_COMPARE;
			end
			seg_start = 1'b1;
		endfunction

		function bit seg_end(int s, int unsigned pos);
			return pos >= flen[s] || fbytes[s][pos] == CHAR_SLASH;
		endfunction

		// Moves every slot matcher on by one topic character and, on the
		// last one, queues whether any live slot ended up matching.
		function void step_topic_char(logic [CHAR_W-1:0] ch, logic last);
			bit any;
			int unsigned c;
			int unsigned n;
			phase_t p;
			any = 1'b0;
			for (int s = 0; s < FILTER_SLOTS_DEF; s++) begin
				p = ph[s];
				c = cur[s];
				n = flen[s];
				if (seg_start && p == PH_COMPARE) begin
					if (c >= n)
						p = PH_FAILED;
					else if (fbytes[s][c] == CHAR_HASH)
						p = PH_MATCHED;
					else if (fbytes[s][c] == CHAR_PLUS && seg_end(s, c + 1))
						p = PH_PLUS;
				end
				if (p == PH_PLUS) begin
					if (ch == CHAR_SLASH) begin
						c += 2;
						p = PH_COMPARE;
					end
				end else if (p == PH_COMPARE) begin
					if (ch == CHAR_SLASH) begin
						if (seg_end(s, c))
							c += 1;
						else
							p = PH_FAILED;
					end else if (c < n && fbytes[s][c] == ch) begin
						c += 1;
					end else begin
						p = PH_FAILED;
					end
				end
				// The end of the topic also closes its final segment.
				if (last && ch != CHAR_SLASH) begin
					if (p == PH_PLUS) begin
						c += 2;
						p = PH_COMPARE;
					end else if (p == PH_COMPARE) begin
						if (seg_end(s, c))
							c += 1;
						else
							p = PH_FAILED;
					end
				end
				if (last && used[s] && !ovf[s] &&
						(p == PH_MATCHED || (p == PH_COMPARE && c >= n)))
					any = 1'b1;
				cur[s] = c;
				ph[s] = p;
			end
			seg_start = (ch == CHAR_SLASH);
			if (last) begin
				expected_matched.push_back(any);
				topics_done++;
				restart();
			end
		endfunction

		function void note_beat(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
				logic [CHAR_W-1:0] ch, logic last);
			case (cmd)
				CMD_APPEND: begin
					used[slot] = 1'b1;
					if (flen[slot] < FILTER_LEN_DEF) begin
						fbytes[slot][flen[slot]] = ch;
						flen[slot]++;
					end else begin
						ovf[slot] = 1'b1;
					end
				end
				CMD_CLEAR: begin
					flen[slot] = 0;
					used[slot] = 1'b0;
					ovf[slot] = 1'b0;
					cur[slot] = 0;
					ph[slot] = PH_COMPARE;
				end
				CMD_TOPIC: step_topic_char(ch, last);
				default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			$display("mismatch: %s", what);
			mismatches++;
		endtask

		task check_match(logic matched);
			bit want;
			if (expected_matched.size() == 0) begin
				report_mismatch($sformatf("result matched=%b with none expected", matched));
				return;
			end
			want = expected_matched.pop_front();
			if (matched !== want)
				report_mismatch($sformatf("matched=%b, expected %b", matched, want));
		endtask

		task report_leftovers();
			while (expected_matched.size() != 0)
				report_mismatch($sformatf("result matched=%b never arrived",
					expected_matched.pop_front()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tfwm_in_if  item_if();
	tfwm_out_if result_if();

	topic_filter_wildcard_match_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	match_scoreboard tracker = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int beat_count = 0;
	int cycle_count = 0;

	string word_tab [7] = '{"a", "b", "ab", "foo", "a+", "+b", "#x"};
	chars_t slot_text [FILTER_SLOTS_DEF];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("topic_filter_wildcard_match_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_if.ready <= 1'(($urandom_range(99) >= recv_stall_pct));
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			tracker.check_match(result_if.matched);
	end

	function automatic chars_t to_chars(string s);
		chars_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic void add_word(ref chars_t q);
		string w;
		w = word_tab[$urandom_range(6)];
		for (int i = 0; i < w.len(); i++)
			q.push_back(w[i]);
	endfunction

	// Segments joined by slashes; with wild set, some segments are '+' or '#'.
	// A leading '#' would match every topic, so it is kept rare.
	function automatic chars_t make_text(bit wild);
		chars_t q;
		int nseg;
		int r;
		nseg = $urandom_range(1, 4);
		for (int k = 0; k < nseg; k++) begin
			if (k > 0)
				q.push_back(CHAR_SLASH);
			r = $urandom_range(19);
			if (wild && r < 3)
				q.push_back(CHAR_PLUS);
			else if (wild && r == 3 && (k > 0 || $urandom_range(9) == 0))
				q.push_back(CHAR_HASH);
			else if (r != 4)
				add_word(q);
		end
		if (q.size() == 0)
			q.push_back("a");
		return q;
	endfunction

	// A topic that a filter should match, slightly mutated now and then.
	function automatic chars_t derive_topic(chars_t f);
		chars_t t;
		chars_t seg;
		for (int i = 0; i <= f.size(); i++) begin
			if (i == f.size() || f[i] == CHAR_SLASH) begin
				if (seg.size() == 1 && seg[0] == CHAR_PLUS) begin
					add_word(t);
				end else if (seg.size() > 0 && seg[0] == CHAR_HASH) begin
					add_word(t);
					if ($urandom_range(1) == 0) begin
						t.push_back(CHAR_SLASH);
						add_word(t);
					end
					break;
				end else begin
					t = {t, seg};
				end
				if (i < f.size())
					t.push_back(CHAR_SLASH);
				seg.delete();
			end else begin
				seg.push_back(f[i]);
			end
		end
		case ($urandom_range(9))
			0: t.push_back(CHAR_SLASH);
			1: if (t.size() > 0) t[$urandom_range(t.size() - 1)] = 8'($urandom_range(97, 98));
			2: if (t.size() > 1) void'(t.pop_back());
			default: ;
		endcase
		if (t.size() == 0)
			t.push_back("a");
		return t;
	endfunction

	task automatic send_beat(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
			logic [CHAR_W-1:0] ch, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			item_if.valid <= 1'b0;
			item_if.cmd <= 2'($urandom_range(3));
			item_if.slot <= 3'($urandom_range(7));
			item_if.char_byte <= 8'($urandom_range(255));
			item_if.last <= 1'($urandom_range(1));
			@(negedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.cmd <= cmd;
		item_if.slot <= slot;
		item_if.char_byte <= ch;
		item_if.last <= last;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		tracker.note_beat(cmd, slot, ch, last);
		if (cmd != CMD_UNUSED)
			beat_count++;
		@(negedge clk);
	endtask

	task automatic write_filter(logic [SLOT_W-1:0] slot, chars_t f);
		send_beat(CMD_CLEAR, slot, 8'($urandom_range(255)), 1'($urandom_range(1)));
		foreach (f[i])
			send_beat(CMD_APPEND, slot, f[i], 1'($urandom_range(1)));
		slot_text[slot] = f;
	endtask

	// With mix set, appends and clears land in the middle of the topic.
	task automatic send_topic(chars_t t, bit mix);
		for (int i = 0; i < t.size(); i++) begin
			if (mix && $urandom_range(24) == 0) begin
				if ($urandom_range(1) == 0)
					send_beat(CMD_APPEND, 3'($urandom_range(7)), "a", 1'($urandom_range(1)));
				else
					send_beat(CMD_CLEAR, 3'($urandom_range(7)), 8'($urandom_range(255)), 1'b0);
			end
			send_beat(CMD_TOPIC, 3'($urandom_range(7)), t[i], 1'(i == t.size() - 1));
		end
	endtask

	initial begin
		chars_t extremes;
		chars_t f;
		int idle_plan [4][2];
		int base;
		int n;
		int r;
		int s;
		idle_plan = '{'{0, 0}, '{88, 0}, '{0, 88}, '{11, 11}};
		extremes = '{8'h00, 8'hFF};
		item_if.valid = 1'b0;
		item_if.cmd = CMD_APPEND;
		item_if.slot = '0;
		item_if.char_byte = '0;
		item_if.last = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty table, trailing slashes on either side, '#' that
		// needs more topic characters, a '+' over byte extremes, an unknown
		// command, and a clear and an append in the middle of a topic.
		send_topic(to_chars("a"), 1'b0);
		send_beat(CMD_APPEND, 3'd0, "a", 1'b1);
		send_beat(CMD_APPEND, 3'd0, CHAR_SLASH, 1'b0);
		send_topic(to_chars("a"), 1'b0);
		send_beat(CMD_CLEAR, 3'd0, 8'h00, 1'b1);
		send_beat(CMD_UNUSED, 3'd0, "x", 1'b1);
		write_filter(3'd7, to_chars("a/#"));
		send_topic(to_chars("a/"), 1'b0);
		write_filter(3'd5, to_chars("a"));
		send_topic(to_chars("a/"), 1'b0);
		send_beat(CMD_CLEAR, 3'd5, 8'hFF, 1'b0);
		send_beat(CMD_APPEND, 3'd0, CHAR_PLUS, 1'b0);
		send_topic(extremes, 1'b0);
		send_beat(CMD_TOPIC, 3'd3, "b", 1'b0);
		send_beat(CMD_CLEAR, 3'd0, 8'h00, 1'b0);
		send_beat(CMD_APPEND, 3'd0, CHAR_HASH, 1'b0);
		send_beat(CMD_TOPIC, 3'd0, CHAR_SLASH, 1'b1);
		send_topic(to_chars("a/z"), 1'b0);

		base = beat_count;
		for (int stage = 0; stage < 4; stage++) begin
			send_idle_pct = idle_plan[stage][0];
			recv_stall_pct = idle_plan[stage][1];
			while (beat_count < base + (stage + 1) * RANDOM_BEATS / 4 ||
					(stage == 3 && tracker.topics_done < MIN_TOPICS)) begin
				r = $urandom_range(99);
				s = $urandom_range(FILTER_SLOTS_DEF - 1);
				if (r < 20) begin
					write_filter(3'(s), make_text(1'b1));
				end else if (r < 23) begin
					send_beat(CMD_CLEAR, 3'(s), 8'($urandom_range(255)), 1'($urandom_range(1)));
					slot_text[s].delete();
				end else if (r < 25) begin
					// Fill a slot to one short of full, exactly full or past it.
					f.delete();
					n = FILTER_LEN_DEF - 1 + $urandom_range(3);
					for (int i = 0; i < n; i++)
						f.push_back((i == 0 && $urandom_range(3) == 0) ? CHAR_HASH : 8'h61);
					write_filter(3'(s), f);
				end else if (r < 33) begin
					send_beat(2'($urandom_range(3)), 3'($urandom_range(7)),
						8'($urandom_range(255)), 1'($urandom_range(1)));
				end else if ($urandom_range(3) != 0 && slot_text[s].size() != 0) begin
					send_topic(derive_topic(slot_text[s]), 1'b1);
				end else begin
					send_topic(make_text(1'b0), 1'b1);
				end
			end
		end
		item_if.valid <= 1'b0;
		recv_stall_pct = 0;

		while (tracker.expected_matched.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		tracker.report_leftovers();
		if (tracker.mismatches == 0)
			$display("topic_filter_wildcard_match_unit_tb OK");
		else
			$display("topic_filter_wildcard_match_unit_tb NOT OK");
		$finish;
	end

endmodule
